### design/rrpg_pkg.sv
// ============================================================================
// rrpg_pkg: shared types and constants of the radial rainbow pixel generator
// Fixed-point widths, register indexes and the pipeline stage records.
// ============================================================================
`default_nettype none
package rrpg_pkg;

   localparam int MaxSize   = 256;
   localparam int FracBits  = 16;
   localparam int RootSteps = 12 + FracBits;          // root bits produced
   localparam int RootW     = RootSteps;              // root width
   localparam int RemW      = RootSteps + 2;          // remainder width
   localparam int NumW      = 16 + FracBits;          // signed numerator width
   localparam int DivSteps  = NumW;                   // quotient bits

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PASTEL = 2'd2;

   localparam logic [FracBits-1:0] THIRD1 = FracBits'(((1 << FracBits) + 1) / 3);
   localparam logic [FracBits-1:0] THIRD2 = FracBits'(((2 << FracBits) + 1) / 3);
   localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;
   localparam logic [30:0] Q_ONE  = 31'h4000_0000;

   // item record carried through the cell chain
   typedef struct packed {
      logic [23:0]     s;        // squared distance, consumed by the root cells
      logic [RootW-1:0] root;
      logic [RemW-1:0]  rem;
      logic [15:0]     t;
      logic [8:0]      h;
      logic            pastel;
   } root_item_type;

   typedef struct packed {
      logic [NumW-1:0] mag;      // magnitude of numerator, shifted out
      logic [NumW-1:0] quo;
      logic [9:0]      rem;
      logic            neg;
      logic [8:0]      h;
      logic            pastel;
   } div_item_type;

endpackage
`default_nettype wire

### design/rrpg_if.sv
// ============================================================================
// rrpg_if: valid/ready channels for request, response and configuration
// Each carries one item with a fixed payload type declared per interface.
// ============================================================================
`default_nettype none
interface rrpg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_x;
   logic [7:0] pixel_y;
   logic [15:0] frame_time;
   modport source(output valid, pixel_x, pixel_y, frame_time, input ready);
   modport sink(input valid, pixel_x, pixel_y, frame_time, output ready);
endinterface

interface rrpg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source(output valid, red, green, blue, input ready);
   modport sink(input valid, red, green, blue, output ready);
endinterface

interface rrpg_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [8:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/rrpg_root_cell.sv
// ============================================================================
// rrpg_root_cell: one digit of the square root
// Takes two radicand bits and settles one root bit, then hands on.
// ============================================================================
`default_nettype none
module rrpg_root_cell (
   input  wire logic                   clock,
   input  wire logic                   enable,
   input  wire rrpg_pkg::root_item_type item_in,
   output rrpg_pkg::root_item_type     item_out
);
   import rrpg_pkg::*;

   root_item_type item_ff, item_in_c;
   logic [RemW-1:0] rem_sh, trial;

   // one restoring step
   always_comb begin
      item_in_c = item_in;
      rem_sh    = {item_in.rem[RemW-3:0], item_in.s[23:22]};
      trial     = {item_in.root[RemW-3:0], 2'b01};
      item_in_c.s = {item_in.s[21:0], 2'b00};
      if (rem_sh >= trial) begin
         item_in_c.rem  = rem_sh - trial;
         item_in_c.root = {item_in.root[RootW-2:0], 1'b1};
      end else begin
         item_in_c.rem  = rem_sh;
         item_in_c.root = {item_in.root[RootW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in_c;
      end
   end
   assign item_out = item_ff;
endmodule
`default_nettype wire

### design/rrpg_div_cell.sv
// ============================================================================
// rrpg_div_cell: one quotient bit of the phase division
// Shifts one numerator bit into the remainder and subtracts the height when it fits.
// ============================================================================
`default_nettype none
module rrpg_div_cell (
   input  wire logic                  clock,
   input  wire logic                  enable,
   input  wire rrpg_pkg::div_item_type item_in,
   output rrpg_pkg::div_item_type     item_out
);
   import rrpg_pkg::*;

   div_item_type item_ff, item_in_c;
   logic [9:0] rem_sh;

   always_comb begin
      item_in_c = item_in;
      rem_sh    = {item_in.rem[8:0], item_in.mag[NumW-1]};
      item_in_c.mag = {item_in.mag[NumW-2:0], 1'b0};
      if (rem_sh >= {1'b0, item_in.h}) begin
         item_in_c.rem = rem_sh - {1'b0, item_in.h};
         item_in_c.quo = {item_in.quo[NumW-2:0], 1'b1};
      end else begin
         item_in_c.rem = rem_sh;
         item_in_c.quo = {item_in.quo[NumW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         item_ff <= item_in_c;
      end
   end
   assign item_out = item_ff;
endmodule
`default_nettype wire

### design/rrpg_color_lane.sv
// ============================================================================
// rrpg_color_lane: phase to channel value
// Pipelined sin^2 by Horner series, one product per stage.
// ============================================================================
`default_nettype none
module rrpg_color_lane (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic [rrpg_pkg::FracBits-1:0] phase,
   input  wire logic                          pastel,
   output logic [7:0]                         value
);
   import rrpg_pkg::*;

   logic [30:0] z_ff  [11];
   logic [31:0] z2_ff [11];
   logic [31:0] h_ff  [11];
   logic        pa_ff [13];
   logic [FracBits-1:0] u_c;
   logic [30:0] u30;
   logic [63:0] p0;
   logic [61:0] pz2, ps, psq;
   logic [62:0] ph [4];
   logic [31:0] hdiv [5];
   logic [30:0] s_ff, sq_ff;
   logic [40:0] v;
   logic [FracBits:0] one_c;

   // fold to [0,1/2] and scale by pi
   always_comb begin
      one_c = {1'b1, {FracBits{1'b0}}};
      if ({1'b0, phase} <= (one_c >> 1)) u_c = phase;
      else u_c = FracBits'(one_c - {1'b0, phase});
      u30 = 31'(u_c) << (30 - FracBits);
      p0  = 64'(u30) * 64'(PI_Q30);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         z_ff[0]  <= p0[60:30];
         pa_ff[0] <= pastel;
         z2_ff[0] <= '0;
         h_ff[0]  <= '0;
      end
   end

   // z2 reaches about 2.5 in Q30, so it needs 32 bits
   assign pz2 = 62'(z_ff[0]) * 62'(z_ff[0]);
   always_ff @(posedge clock) begin
      if (enable) begin
         z_ff[1] <= z_ff[0]; pa_ff[1] <= pa_ff[0];
         z2_ff[1] <= pz2[61:30];
         h_ff[1] <= 32'(Q_ONE);
      end
   end

   // h = 1 - x/d by reciprocal multiply, exact for any 32-bit x
   for (genvar k = 0; k < 5; k++) begin : g_recip
      localparam longint unsigned Dv = (k == 0) ? 110 : (k == 1) ? 72 :
                                       (k == 2) ? 42 : (k == 3) ? 20 : 6;
      localparam int Sh = 32 + $clog2(Dv);
      localparam logic [32:0] Mul = 33'(((64'd1 << Sh) + Dv - 1) / Dv);
      logic [31:0] x_c;
      logic [64:0] pr_c;
      if (k == 0) begin : g_first
         assign x_c = z2_ff[1];
      end else begin : g_next
         assign x_c = h_ff[1+2*k];
      end
      assign pr_c    = 65'(x_c) * 65'(Mul);
      assign hdiv[k] = 32'(Q_ONE) - 32'(pr_c >> Sh);
      always_ff @(posedge clock) begin
         if (enable) begin
            z_ff[2+2*k] <= z_ff[1+2*k]; pa_ff[2+2*k] <= pa_ff[1+2*k];
            z2_ff[2+2*k] <= z2_ff[1+2*k]; h_ff[2+2*k] <= hdiv[k];
         end
      end
   end

   // Horner products z2*h
   for (genvar k = 0; k < 4; k++) begin : g_horner
      assign ph[k] = 63'(z2_ff[2+2*k]) * 63'(h_ff[2+2*k]);
      always_ff @(posedge clock) begin
         if (enable) begin
            z_ff[3+2*k] <= z_ff[2+2*k]; pa_ff[3+2*k] <= pa_ff[2+2*k];
            z2_ff[3+2*k] <= z2_ff[2+2*k]; h_ff[3+2*k] <= ph[k][61:30];
         end
      end
   end

   // s = z*h, sq = s*s, gain
   assign ps  = 62'(z_ff[10]) * 62'(h_ff[10]);
   always_ff @(posedge clock) begin
      if (enable) begin
         s_ff <= ps[60:30]; pa_ff[11] <= pa_ff[10];
      end
   end
   assign psq = 62'(s_ff) * 62'(s_ff);
   always_ff @(posedge clock) begin
      if (enable) begin
         sq_ff <= psq[60:30]; pa_ff[12] <= pa_ff[11];
      end
   end
   assign v = 41'(sq_ff) * (pa_ff[12] ? 41'd510 : 41'd255);
   always_ff @(posedge clock) begin
      if (enable) begin
         value <= (v[40:30] > 11'd255) ? 8'd255 : v[37:30];
      end
   end
endmodule
`default_nettype wire

### design/radial_rainbow_pixel_gen_top.sv
// ============================================================================
// radial_rainbow_pixel_gen_top: animated radial rainbow pixel generator
// Distance root, phase division and sin^2 color lanes as a chain of cells.
// ============================================================================
//  channel | dir | payload                        | handshake
//  req     | in  | pixel_x, pixel_y, frame_time   | valid/ready
//  rsp     | out | red, green, blue               | valid/ready
//  csr     | in  | index, data (9 bits)           | valid/ready, always ready
//
//  One item per clock unless the output stalls; stages: input register, 28 root
//  cells, divide register, 32 divide cells, phase register, 14 lane stages, output register.
//  The whole chain advances only when the output register is empty or taken,
//  so a stalled result holds every stage. Reset clears the valid bits and
//  the registers to width 12, height 12, pastel off.
`default_nettype none
module radial_rainbow_pixel_gen_top (
   input wire logic    clock,
   input wire logic    reset,
   rrpg_req_if.sink    req,
   rrpg_rsp_if.source  rsp,
   rrpg_csr_if.sink    csr
);
   import rrpg_pkg::*;

   localparam int Depth = 1 + RootSteps + 1 + DivSteps + 1 + 14 + 1;

   logic [8:0] width_ff, height_ff;
   logic       pastel_ff;
   logic [Depth-1:0] vld_ff;
   logic       adv;

   // configuration writes
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'd12; height_ff <= 9'd12; pastel_ff <= 1'b0;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_WIDTH:  width_ff  <= csr.data;
            CSR_HEIGHT: height_ff <= csr.data;
            CSR_PASTEL: pastel_ff <= csr.data[0];
            default: ;
         endcase
      end
   end

   // chain advances when the output slot is free or being taken
   assign adv       = !vld_ff[Depth-1] || rsp.ready;
   assign req.ready = adv;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[Depth-2:0], req.valid};
   end
   assign rsp.valid = vld_ff[Depth-1];

   // stage 0: clamp sizes, form squared distance
   logic [8:0] w_c, h_c;
   logic signed [19:0] dx_c, dy_c;
   logic [23:0] s_c;
   always_comb begin
      w_c = (width_ff == 9'd0) ? 9'd1 : (width_ff > 9'(MaxSize)) ? 9'(MaxSize) : width_ff;
      h_c = (height_ff == 9'd0) ? 9'd1 : (height_ff > 9'(MaxSize)) ? 9'(MaxSize) : height_ff;
      dx_c = $signed({1'b0, req.pixel_x, 1'b0}) - $signed({1'b0, w_c}) + 10'sd1;
      dy_c = $signed({1'b0, req.pixel_y, 1'b0}) - $signed({1'b0, h_c}) + 10'sd1;
      s_c  = 24'(dx_c * dx_c) + 24'(dy_c * dy_c);
   end

   root_item_type r_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff.s <= s_c; r_ff.root <= '0; r_ff.rem <= '0;
         r_ff.t <= req.frame_time; r_ff.h <= h_c; r_ff.pastel <= pastel_ff;
      end
   end

   // root cells: first 12 take radicand bits, the rest take zeros
   root_item_type rc [RootSteps+1];
   assign rc[0] = r_ff;
   for (genvar i = 0; i < RootSteps; i++) begin : g_root
      rrpg_root_cell u_cell (.clock(clock), .enable(adv), .item_in(rc[i]),
                             .item_out(rc[i+1]));
   end

   // numerator and sign
   logic signed [NumW:0] num_c;
   div_item_type d_ff;
   always_comb begin
      num_c = $signed({1'b0, rc[RootSteps].t, {(FracBits-2){1'b0}}})
            - $signed({{(NumW+1-RootW){1'b0}}, rc[RootSteps].root});
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff.neg <= num_c[NumW];
         d_ff.mag <= num_c[NumW] ? NumW'(-num_c) : NumW'(num_c);
         d_ff.quo <= '0; d_ff.rem <= '0;
         d_ff.h <= rc[RootSteps].h; d_ff.pastel <= rc[RootSteps].pastel;
      end
   end

   div_item_type dc [DivSteps+1];
   assign dc[0] = d_ff;
   for (genvar i = 0; i < DivSteps; i++) begin : g_div
      rrpg_div_cell u_cell (.clock(clock), .enable(adv), .item_in(dc[i]),
                            .item_out(dc[i+1]));
   end

   // floor for negative numerator: -(ceil(mag/h))
   logic [FracBits-1:0] ph_ff, q_c;
   logic pa_ff;
   always_comb begin
      if (dc[DivSteps].neg)
         q_c = FracBits'(-(dc[DivSteps].quo + ((dc[DivSteps].rem != '0) ? 1 : 0)));
      else
         q_c = dc[DivSteps].quo[FracBits-1:0];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ph_ff <= q_c; pa_ff <= dc[DivSteps].pastel;
      end
   end

   logic [7:0] red_c, green_c, blue_c;
   rrpg_color_lane u_red   (.clock(clock), .enable(adv), .phase(ph_ff),
                            .pastel(pa_ff), .value(red_c));
   rrpg_color_lane u_green (.clock(clock), .enable(adv), .phase(ph_ff + THIRD1),
                            .pastel(pa_ff), .value(green_c));
   rrpg_color_lane u_blue  (.clock(clock), .enable(adv), .phase(ph_ff + THIRD2),
                            .pastel(pa_ff), .value(blue_c));

   // output register
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp.red <= red_c; rsp.green <= green_c; rsp.blue <= blue_c;
      end
   end
endmodule
`default_nettype wire
